>>> rtl/core/db9sb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// db9sb_pkg: shared types and constants for the DB9 six-button pad reader
// Per-port state record, pad mode codes, poll mode codes and line masks.
// ----------------------------------------------------------------------------
package db9sb_pkg;

  // Default number of DB9 ports
  localparam int unsigned NumPortsDef = 2;

  localparam int unsigned LineW = 6;
  localparam int unsigned MapW  = 12;

  // Direction and left/right masks on a pressed-bit sample
  localparam logic [LineW-1:0] DirsMask = 6'h0F;
  localparam logic [LineW-1:0] LrMask   = 6'h0C;

  // Select phase codes
  localparam logic [1:0] PhHigh   = 2'd0;
  localparam logic [1:0] PhLow    = 2'd1;
  localparam logic [1:0] PhExtra  = 2'd2;
  localparam logic [1:0] PhDetect = 2'd3;

  // pad_mode register codes
  typedef enum logic [1:0] {
    PadPlain  = 2'd0,
    PadForce  = 2'd1,
    PadAuto   = 2'd2,
    PadForce2 = 2'd3
  } pad_mode_e;

  // Input mode field codes
  typedef enum logic {
    ModePoll    = 1'b0,
    ModeRestart = 1'b1
  } poll_mode_e;

  // State kept for one port
  typedef struct packed {
    logic [1:0]       phase;
    logic             mux_pad;
    logic [LineW-1:0] hi_snap;
    logic [LineW-1:0] lo_snap;
    logic [LineW-1:0] ex_snap;
    logic [MapW-1:0]  last_map;
  } port_state_t;

endpackage : db9sb_pkg
`default_nettype wire

>>> rtl/core/db9_six_button_pad_reader_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A result is registered and presented in the cycle after its poll transaction.
// Throughput: one poll per cycle; the per-port register update is a single
//   pass of the port step logic, and the output register refills in the cycle
//   it drains, so polls stall only while a result waits under out_stall_i.
// Reset: per-port state, pad_mode and the output register clear to zero,
//   except the select level, which resets high.
// ----------------------------------------------------------------------------
// db9_six_button_pad_reader_core: DB9 six-button pad reader
// Holds per-port phase, pad flag, snapshots and button map; each poll or
// restart transaction yields one result transaction.
// ----------------------------------------------------------------------------
module db9_six_button_pad_reader_core #(
  parameter int unsigned NUM_PORTS = db9sb_pkg::NumPortsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_pad_mode_i,
  // Poll channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic                         port_i,
  input  logic [db9sb_pkg::LineW-1:0]  raw_lines_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         map_updated_o,
  output logic [db9sb_pkg::MapW-1:0]   button_map_o,
  output logic                         select_drive_o,
  output logic                         select_level_o
);
  import db9sb_pkg::*;

  localparam int unsigned PortIdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  pad_mode_e            pad_mode_q;
  port_state_t          port_q [NUM_PORTS];
  port_state_t          port_d [NUM_PORTS];
  logic                 out_valid_q;
  logic                 map_updated_q;
  logic [MapW-1:0]      button_map_q;
  logic                 select_drive_q;
  logic                 select_level_q;

  logic                 accept;
  logic                 in_range;
  logic [PortIdxW-1:0]  port_idx;
  port_state_t          cur_state;
  port_state_t          step_state;
  logic                 step_updated;
  logic                 step_level;
  logic                 restart_mux;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  // Port selection
  assign in_range    = (32'(port_i) < NUM_PORTS);
  assign port_idx    = in_range ? PortIdxW'(port_i) : '0;
  assign cur_state   = port_q[port_idx];
  assign restart_mux = (pad_mode_q != PadPlain);

  db9sb_port_step u_step (
    .cur_i      (cur_state),
    .pad_mode_i (pad_mode_q),
    .sample_i   (~raw_lines_i),
    .nxt_o      (step_state),
    .updated_o  (step_updated),
    .level_o    (step_level)
  );

  // Next per-port state
  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      port_d[i] = port_q[i];
      if (accept && in_range) begin
        if (mode_i == ModeRestart) begin
          port_d[i].phase   = PhHigh;
          port_d[i].mux_pad = restart_mux;
        end else if (port_idx == PortIdxW'(i)) begin
          port_d[i] = step_state;
        end
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_mode_q <= PadPlain;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pad_mode_q <= pad_mode_e'(cfg_pad_mode_i);
    end
  end

  // Per-port state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_q[i] <= port_d[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      map_updated_q  <= 1'b0;
      button_map_q   <= '0;
      select_drive_q <= 1'b0;
      select_level_q <= 1'b1;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        if (!in_range) begin
          map_updated_q  <= 1'b0;
          button_map_q   <= '0;
          select_drive_q <= 1'b0;
          select_level_q <= 1'b1;
        end else if (mode_i == ModeRestart) begin
          map_updated_q  <= 1'b0;
          button_map_q   <= cur_state.last_map;
          select_drive_q <= restart_mux;
          select_level_q <= ~restart_mux;
        end else begin
          map_updated_q  <= step_updated;
          button_map_q   <= step_state.last_map;
          select_drive_q <= step_state.mux_pad;
          select_level_q <= step_level;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign map_updated_o  = map_updated_q;
  assign button_map_o   = button_map_q;
  assign select_drive_o = select_drive_q;
  assign select_level_o = select_level_q;

endmodule : db9_six_button_pad_reader_core
`default_nettype wire

>>> rtl/core/db9sb_port_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// db9sb_port_step: one poll of one port
// Combinational update of a port's phase, pad flag, snapshots and map from
// one pressed-bit sample, plus the resulting select pin level.
// ----------------------------------------------------------------------------
module db9sb_port_step (
  input  db9sb_pkg::port_state_t     cur_i,
  input  db9sb_pkg::pad_mode_e       pad_mode_i,
  input  logic [db9sb_pkg::LineW-1:0] sample_i,
  output db9sb_pkg::port_state_t     nxt_o,
  output logic                       updated_o,
  output logic                       level_o
);
  import db9sb_pkg::*;

  port_state_t      nxt;
  logic [LineW-1:0] snap;
  logic             detect;
  logic [MapW-1:0]  map;

  // Snapshot that belongs to the current phase
  always_comb begin
    case (cur_i.phase)
      PhHigh:  snap = cur_i.hi_snap;
      PhLow:   snap = cur_i.lo_snap;
      default: snap = cur_i.ex_snap;
    endcase
  end

  // Map rebuild from the updated snapshots
  always_comb begin
    map = '0;
    map[3:0] = nxt.hi_snap[3:0];
    if (nxt.hi_snap[4]) begin
      if (cur_i.mux_pad) map[5] = 1'b1;
      else               map[4] = 1'b1;
    end
    if (nxt.hi_snap[5]) begin
      if (cur_i.mux_pad) map[6] = 1'b1;
      else               map[5] = 1'b1;
    end
    if (nxt.lo_snap[4]) map[4] = 1'b1;
    if (nxt.lo_snap[5]) map[7] = 1'b1;
    map[11:8] = nxt.ex_snap[3:0];
  end

  // Poll update
  always_comb begin
    port_state_t res;
    res       = cur_i;
    nxt       = cur_i;
    detect    = 1'b0;
    updated_o = 1'b0;
    if (cur_i.phase == PhDetect) begin
      nxt.phase = PhLow;
    end else if (sample_i != snap) begin
      case (cur_i.phase)
        PhHigh: nxt.hi_snap = sample_i;
        PhLow: begin
          if ((sample_i & DirsMask) == DirsMask) begin
            nxt.phase = PhDetect;
            detect    = 1'b1;
          end else begin
            nxt.lo_snap = sample_i;
          end
        end
        default: nxt.ex_snap = sample_i;
      endcase
    end
    res = nxt;
    if (cur_i.phase != PhDetect && sample_i != snap && !detect) begin
      res.last_map = map;
      updated_o    = 1'b1;
      // Autodetect: no left+right in the low phase means a plain pad
      if (pad_mode_i == PadAuto && cur_i.phase == PhLow && cur_i.mux_pad &&
          (nxt.lo_snap & LrMask) != LrMask) begin
        res.mux_pad  = 1'b0;
        res.phase[0] = 1'b0;
        res.lo_snap  = '0;
        res.ex_snap  = '0;
      end
    end
    // Multiplexed pad toggles the phase and drives select from it
    if (res.mux_pad) begin
      res.phase[0] = ~res.phase[0];
      level_o      = ~res.phase[0];
    end else begin
      level_o = 1'b1;
    end
    nxt_o = res;
  end

endmodule : db9sb_port_step
`default_nettype wire
